// ===== hw/rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants for the arp cache table
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 31;
    localparam int ENTRY_W   = IP_W + MAC_W + TIME_W;
    localparam int REQ_W     = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(60000);

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESP
    } arpc_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, restart scan
        logic scan;     // step the table scan
        logic simple;   // execute clear or tick
        logic commit;   // write back the chosen add slot
        logic respond;  // load the result register
    } arpc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_kind;  // request needs a table scan
        logic scan_done;  // all entries examined
        logic out_busy;   // result register still held
    } arpc_sts_t;

endpackage

// ===== hw/rtl/arpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/arpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// request sequencer: accept, scan, write back, respond
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  arpc_sts_t sts,
    output arpc_cmd_t cmd
);

    arpc_state_t state_reg;
    arpc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.scan_kind)
                begin
                    state_next = ST_RESP;
                end
                else if (sts.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN:
            begin
                cmd.scan   = sts.scan_kind;
                cmd.simple = !sts.scan_kind;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_RESP:
            begin
                cmd.respond = !sts.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/arpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_datapath
// entry storage, scan compare logic, tick counter and result register
// ----------------------------------------------------------------------------
module arpc_datapath
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  arpc_cmd_t                cmd,
    output arpc_sts_t                sts,
    input  logic [IP_W+MAC_W-1:0]    s_tdata,
    input  logic [REQ_W-1:0]         s_tuser,
    input  logic                     cfg_valid,
    input  logic [TIMEOUT_W-1:0]     cfg_data,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [MAC_W-1:0]         m_tdata,
    output logic [0:0]               m_tuser
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // control state
    logic [ENTRIES-1:0]   valid_reg,   valid_next;
    logic [CNT_W-1:0]     rd_idx_reg,  rd_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic                 found_reg,   found_next;
    logic                 free_reg,    free_next;
    logic [REQ_W-1:0]     kind_reg,    kind_next;
    logic [TIME_W-1:0]    tick_reg,    tick_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                 out_vld_reg, out_vld_next;

    // payload
    logic [IP_W-1:0]      ip_reg,        ip_next;
    logic [MAC_W-1:0]     mac_reg,       mac_next;
    logic [IDX_W-1:0]     cmp_idx_reg,   cmp_idx_next;
    logic [IDX_W-1:0]     found_idx_reg, found_idx_next;
    logic [MAC_W-1:0]     found_mac_reg, found_mac_next;
    logic [IDX_W-1:0]     free_idx_reg,  free_idx_next;
    logic [IDX_W-1:0]     best_idx_reg,  best_idx_next;
    logic [TIME_W-1:0]    best_age_reg,  best_age_next;
    logic                 out_hit_reg,   out_hit_next;
    logic [MAC_W-1:0]     out_mac_reg,   out_mac_next;

    // entry memory
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [IP_W-1:0]    ent_ip;
    logic [MAC_W-1:0]   ent_mac;
    logic [TIME_W-1:0]  ent_time;
    logic [TIME_W-1:0]  ent_age;
    logic               ent_valid;
    logic               ent_match;
    logic               scan_kind;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // entry word: time, mac, ip from the top down
    assign ent_ip    = ram_rdata[IP_W-1:0];
    assign ent_mac   = ram_rdata[IP_W+MAC_W-1:IP_W];
    assign ent_time  = ram_rdata[ENTRY_W-1:IP_W+MAC_W];
    assign ent_age   = tick_reg - ent_time;
    assign ent_valid = valid_reg[cmp_idx_reg];
    assign ent_match = ent_valid && (ent_ip == ip_reg);

    assign scan_kind = (kind_reg == REQ_ADD) || (kind_reg == REQ_LOOKUP) ||
                       (kind_reg == REQ_DELETE);

    assign sts.scan_kind = scan_kind;
    assign sts.scan_done = (rd_idx_reg == CNT_W'(ENTRIES)) && !cmp_vld_reg;
    assign sts.out_busy  = out_vld_reg && !m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_mac_reg;
    assign m_tuser  = out_hit_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        kind_next      = kind_reg;
        tick_next      = tick_reg;
        timeout_next   = timeout_reg;
        out_vld_next   = out_vld_reg;
        ip_next        = ip_reg;
        mac_next       = mac_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_idx_next = found_idx_reg;
        found_mac_next = found_mac_reg;
        free_idx_next  = free_idx_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        out_hit_next   = out_hit_reg;
        out_mac_next   = out_mac_reg;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = {tick_reg, mac_reg, ip_reg};

        // match first, then free slot, then oldest entry
        if (found_reg)
        begin
            ram_waddr = found_idx_reg;
        end
        else if (free_reg)
        begin
            ram_waddr = free_idx_reg;
        end
        else
        begin
            ram_waddr = best_idx_reg;
        end

        if (cfg_valid)
        begin
            timeout_next = cfg_data;
        end

        if (cmd.load)
        begin
            kind_next    = s_tuser;
            ip_next      = s_tdata[IP_W-1:0];
            mac_next     = s_tdata[IP_W+MAC_W-1:IP_W];
            rd_idx_next  = '0;
            cmp_vld_next = 1'b0;
            found_next   = 1'b0;
            free_next    = 1'b0;
        end

        if (cmd.scan)
        begin
            // read stage
            if (rd_idx_reg < CNT_W'(ENTRIES))
            begin
                ram_re       = 1'b1;
                rd_idx_next  = rd_idx_reg + CNT_W'(1);
                cmp_vld_next = 1'b1;
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];
            end
            else
            begin
                cmp_vld_next = 1'b0;
            end

            // compare stage, one entry behind the read
            if (cmp_vld_reg)
            begin
                case (kind_reg)
                    REQ_ADD:
                    begin
                        if (ent_match && !found_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = cmp_idx_reg;
                        end
                        if (!ent_valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = cmp_idx_reg;
                        end
                        // strict compare keeps the lowest index on equal ages
                        if ((cmp_idx_reg == '0) || (ent_age > best_age_reg))
                        begin
                            best_age_next = ent_age;
                            best_idx_next = cmp_idx_reg;
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (ent_valid && (ent_age > {1'b0, timeout_reg}))
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                        end
                        else if (ent_match && !found_reg)
                        begin
                            found_next     = 1'b1;
                            found_mac_next = ent_mac;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (ent_match && !found_reg)
                        begin
                            found_next              = 1'b1;
                            valid_next[cmp_idx_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        found_next = found_reg;
                    end
                endcase
            end
        end

        if (cmd.simple)
        begin
            case (kind_reg)
                REQ_CLEAR:
                begin
                    valid_next = '0;
                end
                REQ_TICK:
                begin
                    tick_next = tick_reg + TIME_W'(1);
                end
                default:
                begin
                    tick_next = tick_reg;
                end
            endcase
        end

        if (cmd.commit && (kind_reg == REQ_ADD))
        begin
            ram_we                = 1'b1;
            valid_next[ram_waddr] = 1'b1;
        end

        if (cmd.respond)
        begin
            out_vld_next = 1'b1;
            out_hit_next = found_reg && scan_kind;
            out_mac_next = (found_reg && (kind_reg == REQ_LOOKUP)) ? found_mac_reg : '0;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            kind_reg    <= REQ_ADD;
            tick_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            free_reg    <= free_next;
            kind_reg    <= kind_next;
            tick_reg    <= tick_next;
            timeout_reg <= timeout_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg        <= ip_next;
        mac_reg       <= mac_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        found_mac_reg <= found_mac_next;
        free_idx_reg  <= free_idx_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        out_hit_reg   <= out_hit_next;
        out_mac_reg   <= out_mac_next;
    end

endmodule

// ===== hw/rtl/arp_cache_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_table
// ipv4 to mac address cache with aging, oldest-entry replacement and timeout
// ----------------------------------------------------------------------------
// One request is taken at a time and answered by exactly one result transfer.
// Add, lookup and delete walk the whole entry ram, one entry per cycle through
// its single read port, and add then writes back its chosen slot; clear and
// tick skip the scan and go straight to the response. A new request is
// taken while the previous result still waits on the output. There is no
// clearing pass after reset: the valid bits reset at once, and invalid
// entries are never read for a result. The timeout register may be written at
// any time the block is idle and takes effect on the next lookup.
// ----------------------------------------------------------------------------
module arp_cache_table
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,

    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [79:0]            s_tdata,   // ip_addr [31:0], mac_in [79:32]
    input  logic [2:0]             s_tuser,   // req_type [2:0]

    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata,   // mac_out [47:0]
    output logic [0:0]             m_tuser,   // hit [0]

    // timeout register write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [TIMEOUT_W-1:0]   cfg_data   // timeout_ticks [30:0]
);

    arpc_cmd_t cmd;
    arpc_sts_t sts;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    // sequencer: one request in flight
    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, scan compare and the result register
    arpc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== hw/rtl/arpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_checker
// port-level checks for the arp cache table
// ----------------------------------------------------------------------------
module arpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // a returned address only comes with a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata != 48'd0) |-> m_tuser[0])
        else $error("mac returned without hit");

    // one request at a time: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a new result never appears in the cycle right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result before the request was processed");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (.*);
